FILE: design/mcpb_pkg.sv
// Shared types, constants and lookup functions for the MIDI CC to parameter bus converter.
package mcpb_pkg;

  // Map and controller geometry
  localparam int MAP_ENTRIES        = 128;
  localparam int MAP_AW             = 7;
  localparam int CTL_W              = 6;
  localparam int CONTROLLERS        = 34;
  localparam int SWITCH_CONTROLLERS = 16;

  localparam logic [CTL_W-1:0] CTL_UNMAPPED = 6'd63;
  localparam logic [CTL_W-1:0] CTL_RESET    = 6'd35;

  // Status byte decode
  localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
  localparam logic [7:0] STATUS_CC        = 8'hB0;
  localparam logic [7:0] CHANNEL_MASK     = 8'h0F;

  // Switch quantization thresholds
  localparam logic [7:0] HALF_SPLIT   = 8'd64;
  localparam logic [7:0] THIRD_LO     = 8'd42;
  localparam logic [7:0] THIRD_HI     = 8'd84;
  localparam logic [7:0] QUARTER_LO   = 8'd32;
  localparam logic [7:0] QUARTER_MID  = 8'd64;
  localparam logic [7:0] QUARTER_HI   = 8'd96;
  localparam logic [2:0] POS_TWO      = 3'd2;
  localparam logic [2:0] POS_THREE    = 3'd3;
  localparam logic [2:0] POS_FOUR     = 3'd4;
  localparam logic [1:0] FIELD_ONE    = 2'b01;
  localparam logic [1:0] FIELD_TWO    = 2'b11;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_THRU = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_THRU      = 2'd0,
    OP_MAP_WRITE = 2'd1,
    OP_SELECT    = 2'd2,
    OP_VALUE     = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NUMBER = 2'd1,
    PH_VALUE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BS_IDLE   = 2'd0,
    BS_LOOKUP = 2'd1,
    BS_EMIT   = 2'd2
  } back_state_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [7:0]        data;
    logic [MAP_AW-1:0] map_cc;
    logic [CTL_W-1:0]  map_ctl;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [2:0] shift;
    logic [2:0] count;
  } rom_t;

  // Fixed controller table: address, bit shift, position count
  function automatic rom_t rom_read(input logic [CTL_W-1:0] ctl);
    rom_t e;
    unique case (ctl)
      6'd0:    e = '{8'd0,   3'd6, 3'd4};
      6'd1:    e = '{8'd0,   3'd4, 3'd3};
      6'd2:    e = '{8'd0,   3'd2, 3'd3};
      6'd3:    e = '{8'd0,   3'd0, 3'd3};
      6'd4:    e = '{8'd1,   3'd7, 3'd2};
      6'd5:    e = '{8'd1,   3'd6, 3'd2};
      6'd6:    e = '{8'd1,   3'd5, 3'd2};
      6'd7:    e = '{8'd1,   3'd4, 3'd2};
      6'd8:    e = '{8'd1,   3'd3, 3'd2};
      6'd9:    e = '{8'd1,   3'd2, 3'd2};
      6'd10:   e = '{8'd1,   3'd0, 3'd3};
      6'd11:   e = '{8'd2,   3'd3, 3'd2};
      6'd12:   e = '{8'd2,   3'd2, 3'd2};
      6'd13:   e = '{8'd2,   3'd0, 3'd3};
      6'd14:   e = '{8'd130, 3'd0, 3'd0};
      6'd15:   e = '{8'd129, 3'd0, 3'd0};
      6'd16:   e = '{8'd16,  3'd0, 3'd0};
      6'd17:   e = '{8'd17,  3'd0, 3'd0};
      6'd18:   e = '{8'd18,  3'd0, 3'd0};
      6'd19:   e = '{8'd19,  3'd0, 3'd0};
      6'd20:   e = '{8'd20,  3'd0, 3'd0};
      6'd21:   e = '{8'd21,  3'd0, 3'd0};
      6'd22:   e = '{8'd22,  3'd0, 3'd0};
      6'd23:   e = '{8'd23,  3'd0, 3'd0};
      6'd24:   e = '{8'd24,  3'd0, 3'd0};
      6'd25:   e = '{8'd25,  3'd0, 3'd0};
      6'd26:   e = '{8'd26,  3'd0, 3'd0};
      6'd27:   e = '{8'd27,  3'd0, 3'd0};
      6'd28:   e = '{8'd28,  3'd0, 3'd0};
      6'd29:   e = '{8'd29,  3'd0, 3'd0};
      6'd30:   e = '{8'd30,  3'd0, 3'd0};
      6'd31:   e = '{8'd31,  3'd0, 3'd0};
      6'd32:   e = '{8'd32,  3'd0, 3'd0};
      6'd33:   e = '{8'd33,  3'd0, 3'd0};
      default: e = '{8'd0,   3'd0, 3'd0};
    endcase
    return e;
  endfunction

  // Power-up CC map; every CC not listed is unmapped
  function automatic logic [CTL_W-1:0] default_map(input logic [MAP_AW-1:0] cc);
    logic [CTL_W-1:0] ctl;
    unique case (cc)
      7'd11:   ctl = 6'd0;
      7'd74:   ctl = 6'd1;
      7'd9:    ctl = 6'd2;
      7'd75:   ctl = 6'd3;
      7'd10:   ctl = 6'd17;
      7'd15:   ctl = 6'd18;
      7'd16:   ctl = 6'd19;
      7'd21:   ctl = 6'd22;
      7'd19:   ctl = 6'd23;
      7'd27:   ctl = 6'd24;
      7'd7:    ctl = 6'd27;
      7'd3:    ctl = 6'd28;
      7'd28:   ctl = 6'd30;
      7'd29:   ctl = 6'd31;
      7'd30:   ctl = 6'd32;
      7'd31:   ctl = 6'd33;
      default: ctl = CTL_UNMAPPED;
    endcase
    return ctl;
  endfunction

endpackage

FILE: design/mcpb_front.sv
// Front end: config register, routing and running-status tracking, command classification.
module mcpb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [3:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [7:0]                    midi_byte,
  input  logic [mcpb_pkg::MAP_AW-1:0]   map_cc,
  input  logic [mcpb_pkg::CTL_W-1:0]    map_controller,
  input  logic                          q_full,
  output mcpb_pkg::q_push_t             push
);

  logic [3:0]       channel;
  logic             route;
  logic             route_next;
  mcpb_pkg::phase_t phase;
  mcpb_pkg::phase_t phase_next;
  logic             accept;
  logic             own_cc;

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign own_cc = ((midi_byte & mcpb_pkg::STATUS_TYPE_MASK) == mcpb_pkg::STATUS_CC) &&
                  ((midi_byte & mcpb_pkg::CHANNEL_MASK) == {4'd0, channel});

  // Hold config and routing state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= 4'd0;
      route   <= 1'b0;
      phase   <= mcpb_pkg::PH_IDLE;
    end else begin
      if (cfg_wr_en) begin
        channel <= cfg_wr_data;
      end
      route <= route_next;
      phase <= phase_next;
    end
  end

  // Classify each accepted request into a queue command
  always_comb begin
    route_next       = route;
    phase_next       = phase;
    push.push        = 1'b0;
    push.cmd.op      = mcpb_pkg::OP_THRU;
    push.cmd.data    = midi_byte;
    push.cmd.map_cc  = map_cc;
    push.cmd.map_ctl = map_controller;
    if (accept) begin
      if (mode) begin
        push.push   = 1'b1;
        push.cmd.op = mcpb_pkg::OP_MAP_WRITE;
      end else if (midi_byte[7]) begin
        if (own_cc) begin
          route_next = 1'b1;
          phase_next = mcpb_pkg::PH_NUMBER;
        end else begin
          route_next  = 1'b0;
          push.push   = 1'b1;
          push.cmd.op = mcpb_pkg::OP_THRU;
        end
      end else if (!route) begin
        push.push   = 1'b1;
        push.cmd.op = mcpb_pkg::OP_THRU;
      end else begin
        unique case (phase)
          mcpb_pkg::PH_NUMBER: begin
            push.push   = 1'b1;
            push.cmd.op = mcpb_pkg::OP_SELECT;
            phase_next  = mcpb_pkg::PH_VALUE;
          end
          mcpb_pkg::PH_VALUE: begin
            push.push   = 1'b1;
            push.cmd.op = mcpb_pkg::OP_VALUE;
            phase_next  = mcpb_pkg::PH_NUMBER;
          end
          default: begin
            // drop data bytes while no CC number is expected
            push.push = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/mcpb_queue.sv
// Short command queue between the classifying front end and the executing back end.
module mcpb_queue (
  input  logic              clk,
  input  logic              rst,
  input  mcpb_pkg::q_push_t push,
  output logic              full,
  input  logic              pop,
  output mcpb_pkg::q_head_t head
);

  mcpb_pkg::cmd_t                slots [mcpb_pkg::QUEUE_DEPTH];
  logic [mcpb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mcpb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mcpb_pkg::QPTR_W:0]     count;
  logic                          do_pop;

  assign full       = (count == (mcpb_pkg::QPTR_W+1)'(mcpb_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/mcpb_back.sv
// Back end: CC map memory, controller selection, pot and switch conversion, output register.
module mcpb_back #(
  parameter int SWITCH_GROUPS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  mcpb_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [7:0]        out_byte,
  output logic              last
);

  localparam int GW = (SWITCH_GROUPS > 1) ? $clog2(SWITCH_GROUPS) : 1;

  // CC map memory with per-entry valid bits
  logic [mcpb_pkg::CTL_W-1:0]      map_mem [mcpb_pkg::MAP_ENTRIES];
  logic [mcpb_pkg::MAP_ENTRIES-1:0] map_vld;
  logic                            mem_we;
  logic [mcpb_pkg::MAP_AW-1:0]     rd_addr;
  logic [mcpb_pkg::CTL_W-1:0]      rd_ctl;
  logic                            rd_vld;
  logic [mcpb_pkg::MAP_AW-1:0]     rd_cc;

  // Controller context and switch bytes
  logic [mcpb_pkg::CTL_W-1:0] cur_ctl;
  logic [mcpb_pkg::CTL_W-1:0] cur_ctl_next;
  logic [7:0]                 cur_addr;
  logic [7:0]                 cur_addr_next;
  logic [7:0]                 groups [SWITCH_GROUPS];
  logic                       grp_we;

  // Sequencer, pending words, output register
  mcpb_pkg::back_state_t state;
  mcpb_pkg::back_state_t state_next;
  mcpb_pkg::res_t        pend0;
  mcpb_pkg::res_t        pend0_next;
  mcpb_pkg::res_t        pend1;
  mcpb_pkg::res_t        pend1_next;
  mcpb_pkg::res_t        res;
  mcpb_pkg::res_t        res_next;
  logic                  res_valid;
  logic                  res_valid_next;
  logic                  can_load;

  // Conversion datapath
  mcpb_pkg::rom_t             e;
  mcpb_pkg::rom_t             sel_e;
  logic [mcpb_pkg::CTL_W-1:0] sel_ctl;
  logic [7:0]                 v;
  logic [1:0]                 q;
  logic [1:0]                 fw;
  logic                       cnt_ok;
  logic                       is_switch;
  logic                       is_pot;
  logic                       grp_ok;
  logic [GW-1:0]              gidx;
  logic [9:0]                 fmask;
  logic [9:0]                 fval;
  logic [7:0]                 old_b;
  logic [7:0]                 new_b;
  logic [7:0]                 diff;
  logic                       sw_hit;

  assign rd_addr   = head.cmd.data[mcpb_pkg::MAP_AW-1:0];
  assign can_load  = !res_valid || !out_stall;
  assign out_valid = res_valid;
  assign kind      = res.kind;
  assign out_byte  = res.data;
  assign last      = res.last;

  // Write map entries and register every read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[head.cmd.map_cc] <= head.cmd.map_ctl;
    end
    rd_ctl <= map_mem[rd_addr];
    rd_vld <= map_vld[rd_addr];
    rd_cc  <= rd_addr;
  end

  // Mark written map entries
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (mem_we) begin
      map_vld[head.cmd.map_cc] <= 1'b1;
    end
  end

  // Hold switch group bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SWITCH_GROUPS; i++) begin
        groups[i] <= 8'd0;
      end
    end else if (grp_we) begin
      groups[gidx] <= new_b;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcpb_pkg::BS_IDLE;
      cur_ctl   <= mcpb_pkg::CTL_RESET;
      cur_addr  <= 8'd0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_ctl   <= cur_ctl_next;
      cur_addr  <= cur_addr_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend0 <= pend0_next;
    pend1 <= pend1_next;
    res   <= res_next;
  end

  // Quantize the value and merge it into its switch byte
  always_comb begin
    e         = mcpb_pkg::rom_read(cur_ctl);
    v         = head.cmd.data;
    is_switch = cur_ctl < mcpb_pkg::CTL_W'(mcpb_pkg::SWITCH_CONTROLLERS);
    is_pot    = !is_switch && (cur_ctl < mcpb_pkg::CTL_W'(mcpb_pkg::CONTROLLERS));
    grp_ok    = cur_addr < 8'(SWITCH_GROUPS);
    gidx      = cur_addr[GW-1:0];
    old_b     = groups[gidx];
    fw        = 2'b00;
    q         = 2'd0;
    cnt_ok    = 1'b1;
    unique case (e.count)
      mcpb_pkg::POS_TWO: begin
        fw = mcpb_pkg::FIELD_ONE;
        q  = (v < mcpb_pkg::HALF_SPLIT) ? 2'd0 : 2'd1;
      end
      mcpb_pkg::POS_THREE: begin
        fw = mcpb_pkg::FIELD_TWO;
        q  = (v < mcpb_pkg::THIRD_LO) ? 2'd0 : (v < mcpb_pkg::THIRD_HI) ? 2'd1 : 2'd2;
      end
      mcpb_pkg::POS_FOUR: begin
        fw = mcpb_pkg::FIELD_TWO;
        q  = (v < mcpb_pkg::QUARTER_LO) ? 2'd0 :
             (v < mcpb_pkg::QUARTER_MID) ? 2'd1 :
             (v < mcpb_pkg::QUARTER_HI) ? 2'd2 : 2'd3;
      end
      default: cnt_ok = 1'b0;
    endcase
    fmask  = {8'd0, fw} << e.shift;
    fval   = {8'd0, q} << e.shift;
    new_b  = (old_b & ~fmask[7:0]) | fval[7:0];
    diff   = new_b ^ old_b;
    sw_hit = is_switch && grp_ok && cnt_ok && (diff != 8'd0);
  end

  // Sequence commands and emit results
  always_comb begin
    state_next     = state;
    cur_ctl_next   = cur_ctl;
    cur_addr_next  = cur_addr;
    pend0_next     = pend0;
    pend1_next     = pend1;
    res_next       = res;
    res_valid_next = res_valid && out_stall;
    pop            = 1'b0;
    mem_we         = 1'b0;
    grp_we         = 1'b0;
    sel_ctl        = rd_vld ? rd_ctl : mcpb_pkg::default_map(rd_cc);
    sel_e          = mcpb_pkg::rom_read(sel_ctl);
    unique case (state)
      mcpb_pkg::BS_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            mcpb_pkg::OP_MAP_WRITE: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            mcpb_pkg::OP_THRU: begin
              if (can_load) begin
                pop            = 1'b1;
                res_next       = '{mcpb_pkg::KIND_THRU, head.cmd.data, 1'b1};
                res_valid_next = 1'b1;
              end
            end
            mcpb_pkg::OP_SELECT: begin
              pop        = 1'b1;
              state_next = mcpb_pkg::BS_LOOKUP;
            end
            mcpb_pkg::OP_VALUE: begin
              if (sw_hit) begin
                if (can_load) begin
                  pop            = 1'b1;
                  grp_we         = 1'b1;
                  res_next       = '{mcpb_pkg::KIND_ADDR, cur_addr, 1'b0};
                  res_valid_next = 1'b1;
                  pend0_next     = '{mcpb_pkg::KIND_DATA, diff, 1'b0};
                  pend1_next     = '{mcpb_pkg::KIND_DATA, new_b, 1'b1};
                  state_next     = mcpb_pkg::BS_EMIT;
                end
              end else if (is_pot) begin
                if (can_load) begin
                  pop            = 1'b1;
                  res_next       = '{mcpb_pkg::KIND_ADDR, cur_addr, 1'b0};
                  res_valid_next = 1'b1;
                  pend1_next     = '{mcpb_pkg::KIND_DATA, {v[6:0], 1'b0}, 1'b1};
                  pend0_next     = pend1_next;
                  state_next     = mcpb_pkg::BS_EMIT;
                end
              end else begin
                // drop values that change nothing
                pop = 1'b1;
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      mcpb_pkg::BS_LOOKUP: begin
        cur_ctl_next  = sel_ctl;
        cur_addr_next = (sel_ctl < mcpb_pkg::CTL_W'(mcpb_pkg::CONTROLLERS)) ?
                        sel_e.addr : 8'd0;
        state_next    = mcpb_pkg::BS_IDLE;
      end
      mcpb_pkg::BS_EMIT: begin
        if (can_load) begin
          res_next       = pend0;
          res_valid_next = 1'b1;
          pend0_next     = pend1;
          if (pend0.last) begin
            state_next = mcpb_pkg::BS_IDLE;
          end
        end
      end
      default: state_next = mcpb_pkg::BS_IDLE;
    endcase
  end

endmodule

FILE: design/midi_cc_to_param_bus_converter_top.sv
// Top level of the MIDI CC to parameter bus converter.
// Usage:
//   Input channel (in_valid/in_stall) carries one request per MIDI byte or map write
//   (mode = 1 writes map_controller into the entry of map_cc and gives no result).
//   Output channel (out_valid/out_stall) carries result words: kind, out_byte and
//   last, which marks the final word caused by one request.
//   cfg_wr_en/cfg_wr_data set the MIDI channel whose control changes are converted.
// Path: with the command queue empty and the back end idle, the first result word of a
//   request passes through the queue and then the output register.
// Back end work: a thru byte or map write needs no extra back-end state, a CC number
//   passes through the lookup state (registered map memory read), a pot value gives
//   address and data words and a changed switch gives address, mask and byte words,
//   all limited by the single output register. The front end takes a request every
//   cycle while the 4-entry command queue has room; in_stall rises when it is full.
// Reset: routing goes to thru, the map returns to its power-up contents through
//   per-entry valid bits (no clearing pass), switch bytes clear, channel is 0.
// Receiver stall: the output word holds, the back end stops at its next word to emit,
//   the queue fills and then the input stalls.
module midi_cc_to_param_bus_converter_top #(
  parameter int SWITCH_GROUPS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] midi_byte,
  input  logic [6:0] map_cc,
  input  logic [5:0] map_controller,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       last
);

  mcpb_pkg::q_push_t push;
  mcpb_pkg::q_head_t head;
  logic              q_full;
  logic              pop;

  mcpb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .midi_byte      (midi_byte),
    .map_cc         (map_cc),
    .map_controller (map_controller),
    .q_full         (q_full),
    .push           (push)
  );

  mcpb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  mcpb_back #(
    .SWITCH_GROUPS (SWITCH_GROUPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

FILE: tb/cc_conversion_checker.sv
// Checker that predicts and compares the parameter bus words of the CC converter.
module cc_conversion_checker #(
  parameter int   SWITCH_GROUPS = 3,
  parameter logic MAP_MODE      = 1'b1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       mode,
  input  logic [7:0] midi_byte,
  input  logic [6:0] map_cc,
  input  logic [5:0] map_controller,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic [7:0] out_byte,
  input  logic       last,
  output int         fail_count,
  output int         words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Switch controllers: group byte address, bit shift and number of positions
  localparam logic [7:0] GROUP_OF [mcpb_pkg::SWITCH_CONTROLLERS] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd130, 8'd129};
  localparam logic [2:0] SHIFT_OF [mcpb_pkg::SWITCH_CONTROLLERS] = '{
    3'd6, 3'd4, 3'd2, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4,
    3'd3, 3'd2, 3'd0, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] POSNS_OF [mcpb_pkg::SWITCH_CONTROLLERS] = '{
    3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd0, 3'd0};

  // Power-up CC assignments
  localparam logic [6:0] BOOT_CC [16] = '{
    7'd11, 7'd74, 7'd9, 7'd75, 7'd10, 7'd15, 7'd16, 7'd21,
    7'd19, 7'd27, 7'd7, 7'd3, 7'd28, 7'd29, 7'd30, 7'd31};
  localparam logic [5:0] BOOT_CTL [16] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd17, 6'd18, 6'd19, 6'd22,
    6'd23, 6'd24, 6'd27, 6'd28, 6'd30, 6'd31, 6'd32, 6'd33};

  logic [3:0]       listen_ch;
  logic             route_cc;
  mcpb_pkg::phase_t phase;
  logic [5:0]       cur_ctl;
  logic [7:0]       cur_addr;
  logic [7:0]       group_byte [SWITCH_GROUPS];
  logic [5:0]       cc_to_ctl [mcpb_pkg::MAP_ENTRIES];
  mcpb_pkg::res_t   words_due [$];
  int               errs = 0;

  task automatic restore_power_up();
    listen_ch = 4'd0;
    route_cc  = 1'b0;
    phase     = mcpb_pkg::PH_IDLE;
    cur_ctl   = mcpb_pkg::CTL_RESET;
    cur_addr  = 8'd0;
    foreach (group_byte[g]) group_byte[g] = 8'd0;
    foreach (cc_to_ctl[c]) cc_to_ctl[c] = mcpb_pkg::CTL_UNMAPPED;
    foreach (BOOT_CC[p]) cc_to_ctl[BOOT_CC[p]] = BOOT_CTL[p];
    words_due.delete();
  endtask

  task automatic queue_word(input mcpb_pkg::kind_t k, input logic [7:0] b, input logic l);
    mcpb_pkg::res_t w;
    w.kind = k;
    w.data = b;
    w.last = l;
    words_due.push_back(w);
  endtask

  // Turn a CC value into a pot write or a switch group update
  task automatic apply_value(input logic [7:0] v);
    logic [7:0] fld, q, oldb, newb, mask;
    logic [2:0] sh;
    logic       ok;
    if (cur_ctl < mcpb_pkg::SWITCH_CONTROLLERS) begin
      sh = SHIFT_OF[cur_ctl[3:0]];
      ok = 1'b1;
      fld = 8'd0;
      q = 8'd0;
      case (POSNS_OF[cur_ctl[3:0]])
        3'd2: begin
          fld = 8'd1;
          q = (v < 64) ? 8'd0 : 8'd1;
        end
        3'd3: begin
          fld = 8'd3;
          q = (v < 42) ? 8'd0 : (v < 84) ? 8'd1 : 8'd2;
        end
        3'd4: begin
          fld = 8'd3;
          q = (v < 32) ? 8'd0 : (v < 64) ? 8'd1 : (v < 96) ? 8'd2 : 8'd3;
        end
        default: ok = 1'b0;
      endcase
      if (ok && cur_addr < SWITCH_GROUPS) begin
        oldb = group_byte[cur_addr];
        newb = (oldb & ~(fld << sh)) | (q << sh);
        mask = newb ^ oldb;
        if (mask != 8'd0) begin
          group_byte[cur_addr] = newb;
          queue_word(mcpb_pkg::KIND_ADDR, cur_addr, 1'b0);
          queue_word(mcpb_pkg::KIND_DATA, mask, 1'b0);
          queue_word(mcpb_pkg::KIND_DATA, newb, 1'b1);
        end
      end
    end else if (cur_ctl < mcpb_pkg::CONTROLLERS) begin
      queue_word(mcpb_pkg::KIND_ADDR, cur_addr, 1'b0);
      queue_word(mcpb_pkg::KIND_DATA, {v[6:0], 1'b0}, 1'b1);
    end
  endtask

  // Advance the model by one accepted request
  task automatic convert_request(input logic m, input logic [7:0] b,
                                 input logic [6:0] cc, input logic [5:0] ctl);
    if (m == MAP_MODE) begin
      cc_to_ctl[cc] = ctl;
    end else if (b[7]) begin
      if ((b & mcpb_pkg::STATUS_TYPE_MASK) == mcpb_pkg::STATUS_CC &&
          (b & mcpb_pkg::CHANNEL_MASK) == {4'd0, listen_ch}) begin
        route_cc = 1'b1;
        phase = mcpb_pkg::PH_NUMBER;
      end else begin
        route_cc = 1'b0;
        queue_word(mcpb_pkg::KIND_THRU, b, 1'b1);
      end
    end else if (!route_cc) begin
      queue_word(mcpb_pkg::KIND_THRU, b, 1'b1);
    end else if (phase == mcpb_pkg::PH_NUMBER) begin
      cur_ctl = cc_to_ctl[b[6:0]];
      if (cur_ctl < mcpb_pkg::SWITCH_CONTROLLERS) cur_addr = GROUP_OF[cur_ctl[3:0]];
      else if (cur_ctl < mcpb_pkg::CONTROLLERS) cur_addr = {2'b00, cur_ctl};
      else cur_addr = 8'd0;
      phase = mcpb_pkg::PH_VALUE;
    end else if (phase == mcpb_pkg::PH_VALUE) begin
      phase = mcpb_pkg::PH_NUMBER;
      apply_value(b);
    end
  endtask

  // Compare one delivered word against the oldest prediction
  task automatic compare_word();
    mcpb_pkg::res_t want;
    if (words_due.size() == 0) begin
      errs++;
      $error("word with none predicted: kind %0d out_byte 0x%02h last %0b",
             kind, out_byte, last);
    end else begin
      want = words_due.pop_front();
      if (kind !== want.kind) begin
        errs++;
        $error("kind: expected %0d, got %0d", want.kind, kind);
      end
      if (out_byte !== want.data) begin
        errs++;
        $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte);
      end
      if (last !== want.last) begin
        errs++;
        $error("last: expected %0b, got %0b", want.last, last);
      end
    end
  endtask

  // Outputs are checked before inputs: no word leaves in the cycle its request enters.
  // A channel write takes effect for requests after this edge.
  always @(posedge clk) begin
    if (rst) begin
      restore_power_up();
    end else begin
      if (out_valid && !out_stall) compare_word();
      if (in_valid && !in_stall) convert_request(mode, midi_byte, map_cc, map_controller);
      if (cfg_wr_en) listen_ch = cfg_wr_data;
    end
    fail_count <= errs;
    words_pending <= words_due.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the converter testbench: clock, reset, request and stall traffic, final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   GROUPS      = 3;
  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_MAP    = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   SETTLE_CYC  = 24;
  localparam int   PHASE_REQS  = 60;

  localparam logic [6:0] HOT_CC [16] = '{
    7'd11, 7'd74, 7'd9, 7'd75, 7'd10, 7'd15, 7'd16, 7'd21,
    7'd19, 7'd27, 7'd7, 7'd3, 7'd28, 7'd29, 7'd30, 7'd31};
  localparam logic [7:0] EDGE_VAL [12] = '{
    8'd0, 8'd31, 8'd32, 8'd41, 8'd42, 8'd63, 8'd64, 8'd83, 8'd84, 8'd95, 8'd96, 8'd127};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;
  logic       in_valid = 1'b0;
  logic       mode = 1'b0;
  logic [7:0] midi_byte = 8'd0;
  logic [6:0] map_cc = 7'd0;
  logic [5:0] map_controller = 6'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  int         fail_count;
  int         words_pending;

  logic [3:0] chan = 4'd0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;
  bit         hold_off = 1'b0;
  int         stall_left = 0;
  int         reqs_sent = 0;
  int         cycles = 0;

  midi_cc_to_param_bus_converter_top #(.SWITCH_GROUPS(GROUPS)) dut (.*);

  cc_conversion_checker #(.SWITCH_GROUPS(GROUPS), .MAP_MODE(MODE_MAP)) checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no gap, sometimes short, rarely long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [6:0] pick_cc();
    if ($urandom_range(0, 9) < 7) return HOT_CC[$urandom_range(0, 15)];
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [5:0] pick_ctl();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 6'($urandom_range(0, 15));
    if (r < 85) return 6'($urandom_range(16, 33));
    return 6'($urandom_range(34, 63));
  endfunction

  function automatic logic [7:0] pick_value();
    if ($urandom_range(0, 9) < 3) return EDGE_VAL[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 127));
  endfunction

  // Present one request, hold it until accepted
  task automatic send_req(input logic m, input logic [7:0] b,
                          input logic [6:0] cc, input logic [5:0] ctl);
    int gap;
    gap = in_calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    midi_byte <= b;
    map_cc <= cc;
    map_controller <= ctl;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  // Unused fields of a request carry random bits
  task automatic send_byte(input logic [7:0] b);
    send_req(MODE_BYTE, b, 7'($urandom), 6'($urandom));
  endtask

  task automatic send_map(input logic [6:0] cc, input logic [5:0] ctl);
    send_req(MODE_MAP, 8'($urandom), cc, ctl);
  endtask

  task automatic send_cc(input logic [6:0] cc, input logic [7:0] v);
    send_byte({1'b0, cc});
    send_byte(v);
  endtask

  // Drain predicted words, then let any silent work finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    hold_off <= 1'b1;
    repeat (SETTLE_CYC) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic set_channel(input logic [3:0] ch);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ch;
    chan = ch;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly control change streams with random content, the rest other traffic and noise
  task automatic random_traffic(input int count);
    int stop_at;
    int r;
    stop_at = reqs_sent + count;
    while (reqs_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) in_calm = ~in_calm;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 4) != 0) send_byte(mcpb_pkg::STATUS_CC | {4'd0, chan});
        repeat ($urandom_range(1, 4)) begin
          send_byte({1'b0, pick_cc()});
          if ($urandom_range(0, 9) != 0) send_byte(pick_value());
        end
      end else if (r < 65) begin
        send_map(pick_cc(), pick_ctl());
      end else if (r < 80) begin
        send_byte(8'($urandom_range(128, 255)));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 127)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver stalls, with quiet stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) out_calm <= ~out_calm;
    if (rst || hold_off || out_calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pause_len();
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("midi_cc_to_param_bus_converter_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_channel(4'd0);

    // Thru routing, including a CC status for another channel
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(mcpb_pkg::STATUS_CC | 8'h03);
    // Own channel: switch change, unchanged switch, three-way switch, pot, unmapped
    send_byte(mcpb_pkg::STATUS_CC);
    send_cc(7'd11, 8'd127);
    send_cc(7'd11, 8'd100);
    send_cc(7'd75, 8'd127);
    send_cc(7'd10, 8'd127);
    send_cc(7'd1, 8'd5);
    // Remapped entries: highest pot, and a manual controller that does nothing
    send_map(7'd127, 6'd33);
    send_cc(7'd127, 8'd0);
    send_map(7'd0, 6'd14);
    send_cc(7'd0, 8'd64);
    // Realtime status drops back to thru
    send_byte(8'hF8);
    send_byte(8'h40);
    settle();

    set_channel(4'd15);
    random_traffic(PHASE_REQS);
    settle();
    set_channel(4'($urandom_range(1, 14)));
    random_traffic(PHASE_REQS);
    settle();
    set_channel(4'd0);
    random_traffic(PHASE_REQS);
    settle();
    set_channel(4'($urandom_range(0, 15)));
    random_traffic(PHASE_REQS);
    settle();

    if (fail_count == 0) begin
      $display("midi_cc_to_param_bus_converter_top: match");
    end else begin
      $display("midi_cc_to_param_bus_converter_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mcpb_pkg.sv
design/mcpb_front.sv
design/mcpb_queue.sv
design/mcpb_back.sv
design/midi_cc_to_param_bus_converter_top.sv
tb/cc_conversion_checker.sv
tb/testbench.sv
